// ----- rtl/ptbl_pkg.sv -----
package ptbl_pkg;

	// default sizing
	localparam int PEER_SLOTS_DEF      = 64;
	localparam int TOKEN_FRAC_BITS_DEF = 8;

	// fixed field widths
	localparam int SLOT_IN_W   = 6;
	localparam int SLOT_RANGE  = 1 << SLOT_IN_W;
	localparam int COST_W      = 16;
	localparam int WHOLE_W     = 16;
	localparam int TIME_W      = 32;
	localparam int VIOL_W      = 16;
	localparam int S_TDATA_W   = 56;   // slot 6 + cost 16 + now 32, padded to bytes
	localparam int CFG_ADDR_W  = 2;

	// opcodes
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ENABLED  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RATE     = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_LIMIT    = 2'd3;

	// reset values
	localparam logic               ENABLED_RST    = 1'b1;
	localparam logic [WHOLE_W-1:0] CAPACITY_RST   = 16'd100;
	localparam int                 RATE_RST_WHOLE = 10;     // whole tokens per second
	localparam logic [VIOL_W-1:0]  LIMIT_RST      = 16'd10;
	localparam logic [VIOL_W-1:0]  VIOL_MAX       = 16'hFFFF;

	typedef struct packed {
		logic allowed;
		logic ban;
	} lim_flags_t;

endpackage

// ----- rtl/ptbl_mem.sv -----
module ptbl_mem import ptbl_pkg::*; #(
	parameter int DEPTH = PEER_SLOTS_DEF,
	parameter int WIDTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ptbl_upd.sv -----
module ptbl_upd import ptbl_pkg::*; #(
	parameter int TOKEN_FRAC_BITS = TOKEN_FRAC_BITS_DEF
) (
	input  logic [WHOLE_W+TOKEN_FRAC_BITS-1:0]    tok_in,
	input  logic [VIOL_W-1:0]                     viol_in,
	input  logic [WHOLE_W+TOKEN_FRAC_BITS+30:0]   prod,
	input  logic                                  refill_en,
	input  logic [WHOLE_W+TOKEN_FRAC_BITS-1:0]    need,
	input  logic [WHOLE_W+TOKEN_FRAC_BITS-1:0]    full,
	input  logic [VIOL_W-1:0]                     limit,
	output logic [WHOLE_W+TOKEN_FRAC_BITS-1:0]    tok_out,
	output logic [VIOL_W-1:0]                     viol_out,
	output lim_flags_t                            flags
);

	localparam int TOK_W = WHOLE_W + TOKEN_FRAC_BITS;

	logic [TOK_W:0]   sum;
	logic             prod_big;
	logic [TOK_W-1:0] level;
	logic [VIOL_W-1:0] viol_inc;

	always_comb begin
		prod_big = |prod[TOK_W+30:TOK_W];
		sum = {1'b0, tok_in} + {1'b0, prod[TOK_W-1:0]};
		if (!refill_en) begin
			level = tok_in;
		end else if (prod_big || (sum > {1'b0, full})) begin
			level = full;
		end else begin
			level = sum[TOK_W-1:0];
		end

		viol_inc = (viol_in != VIOL_MAX) ? viol_in + VIOL_W'(1) : viol_in;

		flags = '0;
		if (level >= need) begin
			tok_out = level - need;
			viol_out = viol_in;
			flags.allowed = 1'b1;
		end else begin
			tok_out = level;
			if (viol_inc >= limit) begin
				viol_out = '0;
				flags.ban = 1'b1;
			end else begin
				viol_out = viol_inc;
			end
		end
	end

endmodule

// ----- rtl/per_peer_token_bucket_limiter.sv -----
// channel   dir  signals                          word
// s_axis    in   tvalid tready tdata[55:0] tuser  peer_slot, cost, now_seconds; tuser=opcode
// m_axis    out  tvalid tready tdata              allowed, tokens_left, violation_count,
//                                                 ban_event, entry_created, entry_found
// cfg       in   cfg_we cfg_addr cfg_wdata        register writes, no read-back
//
// Each word goes through accept with table read, refill multiply, then update and
// write-back; the read-modify-write of one slot keeps a single word in flight.
// The next word is accepted in the cycle after the result is loaded, even if
// m_axis is still stalled; a stalled m_axis holds the update stage.
// Reset clears valid bits and loads config defaults; the token table itself needs no clearing.
module per_peer_token_bucket_limiter import ptbl_pkg::*; #(
	parameter int PEER_SLOTS      = PEER_SLOTS_DEF,
	parameter int TOKEN_FRAC_BITS = TOKEN_FRAC_BITS_DEF,
	localparam int TOK_W          = WHOLE_W + TOKEN_FRAC_BITS,
	localparam int OUT_BITS       = TOK_W + VIOL_W + 4,
	localparam int M_TDATA_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // peer_slot, cost, now_seconds, zero pad
	input  logic                  s_axis_tuser,   // opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,   // allowed, tokens_left, violation_count,
	                                              // ban_event, entry_created, entry_found, pad
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [TOK_W-1:0]      cfg_wdata
);

	// only the first 64 slots can ever be addressed
	localparam int USED_SLOTS = (PEER_SLOTS < SLOT_RANGE) ? PEER_SLOTS : SLOT_RANGE;
	localparam int SLOT_W     = $clog2(USED_SLOTS);
	localparam int ENTRY_W    = TOK_W + TIME_W + VIOL_W;
	localparam int PROD_W     = TOK_W + 31;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_FIN} state_t;

	state_t state_q;

	// config
	logic              enabled_q;
	logic [WHOLE_W-1:0] capacity_q;
	logic [TOK_W-1:0]  rate_q;
	logic [VIOL_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= ENABLED_RST;
			capacity_q <= CAPACITY_RST;
			rate_q <= TOK_W'(RATE_RST_WHOLE) << TOKEN_FRAC_BITS;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLED:  enabled_q <= cfg_wdata[0];
				REG_CAPACITY: capacity_q <= cfg_wdata[WHOLE_W-1:0];
				REG_RATE:     rate_q <= cfg_wdata;
				REG_LIMIT:    limit_q <= cfg_wdata[VIOL_W-1:0];
				default: ;
			endcase
		end
	end

	// slot folding table
	logic [SLOT_W-1:0] slot_map [SLOT_RANGE];
	for (genvar g = 0; g < SLOT_RANGE; g++) begin : g_slot
		assign slot_map[g] = SLOT_W'(g % USED_SLOTS);
	end

	logic in_acc;
	logic [SLOT_W-1:0] in_slot;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign in_slot = slot_map[s_axis_tdata[SLOT_IN_W-1:0]];

	// latched word
	logic              op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TOK_W-1:0]  need_q;
	logic [TIME_W-1:0] now_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= s_axis_tuser;
			slot_q <= in_slot;
			need_q <= TOK_W'(s_axis_tdata[SLOT_IN_W +: COST_W]) << TOKEN_FRAC_BITS;
			now_q <= s_axis_tdata[SLOT_IN_W+COST_W +: TIME_W];
		end
	end

	// table
	logic [USED_SLOTS-1:0] valid_q;
	logic                  mem_we;
	logic [ENTRY_W-1:0]    mem_wdata;
	logic [ENTRY_W-1:0]    mem_rdata;

	ptbl_mem #(
		.DEPTH (USED_SLOTS),
		.WIDTH (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (mem_wdata),
		.re    (in_acc),
		.raddr (in_slot),
		.rdata (mem_rdata)
	);

	// refill stage
	logic [TOK_W-1:0]  full;
	logic              found_s1;
	logic              create_s1;
	logic [TOK_W-1:0]  tok_s1;
	logic [TIME_W-1:0] stamp_s1;
	logic [VIOL_W-1:0] viol_s1;
	logic [TIME_W-1:0] diff_s1;

	assign full = TOK_W'(capacity_q) << TOKEN_FRAC_BITS;

	always_comb begin
		found_s1 = valid_q[slot_q];
		create_s1 = !found_s1 && (op_q == OP_CHECK) && enabled_q;
		// a new entry starts full and stamped now, so it sees no refill
		if (create_s1) begin
			tok_s1 = full;
			stamp_s1 = now_q;
			viol_s1 = '0;
		end else begin
			tok_s1 = mem_rdata[TOK_W-1:0];
			stamp_s1 = mem_rdata[TOK_W +: TIME_W];
			viol_s1 = mem_rdata[TOK_W+TIME_W +: VIOL_W];
		end
		diff_s1 = now_q - stamp_s1;
	end

	logic              found_s2;
	logic              create_s2;
	logic              refill_s2;
	logic [TOK_W-1:0]  tok_s2;
	logic [TIME_W-1:0] stamp_s2;
	logic [VIOL_W-1:0] viol_s2;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			found_s2 <= found_s1;
			create_s2 <= create_s1;
			refill_s2 <= (diff_s1 != '0) && !diff_s1[TIME_W-1];
			tok_s2 <= tok_s1;
			stamp_s2 <= stamp_s1;
			viol_s2 <= viol_s1;
			prod_s2 <= PROD_W'(rate_q) * PROD_W'(diff_s1[TIME_W-2:0]);
		end
	end

	// update stage
	logic [TOK_W-1:0]  tok_new;
	logic [VIOL_W-1:0] viol_new;
	lim_flags_t        flags;

	ptbl_upd #(
		.TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
	) u_upd (
		.tok_in    (tok_s2),
		.viol_in   (viol_s2),
		.prod      (prod_s2),
		.refill_en (refill_s2),
		.need      (need_q),
		.full      (full),
		.limit     (limit_q),
		.tok_out   (tok_new),
		.viol_out  (viol_new),
		.flags     (flags)
	);

	logic out_load;
	logic do_update;
	assign out_load = (state_q == ST_FIN) && (!m_axis_tvalid || m_axis_tready);
	assign do_update = (op_q == OP_CHECK) && enabled_q;
	assign mem_we = out_load && do_update;
	assign mem_wdata = {viol_new, (refill_s2 ? now_q : stamp_s2), tok_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (out_load) begin
			if (op_q == OP_REMOVE) begin
				valid_q[slot_q] <= 1'b0;
			end else if (enabled_q) begin
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	// sequencer and result register
	logic              res_allowed_q;
	logic [TOK_W-1:0]  res_tok_q;
	logic [VIOL_W-1:0] res_viol_q;
	logic              res_ban_q;
	logic              res_created_q;
	logic              res_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			res_allowed_q <= 1'b0;
			res_tok_q <= '0;
			res_viol_q <= '0;
			res_ban_q <= 1'b0;
			res_created_q <= 1'b0;
			res_found_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						res_found_q <= found_s2;
						if (op_q == OP_REMOVE) begin
							res_allowed_q <= 1'b0;
							res_tok_q <= '0;
							res_viol_q <= '0;
							res_ban_q <= 1'b0;
							res_created_q <= 1'b0;
						end else if (!enabled_q) begin
							// pass-through: report the stored entry untouched
							res_allowed_q <= 1'b1;
							res_tok_q <= found_s2 ? tok_s2 : '0;
							res_viol_q <= found_s2 ? viol_s2 : '0;
							res_ban_q <= 1'b0;
							res_created_q <= 1'b0;
						end else begin
							res_allowed_q <= flags.allowed;
							res_tok_q <= tok_new;
							res_viol_q <= viol_new;
							res_ban_q <= flags.ban;
							res_created_q <= create_s2;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tdata = M_TDATA_W'({res_found_q, res_created_q, res_ban_q,
		res_viol_q, res_tok_q, res_allowed_q});

`ifndef ASSERT_OFF
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL) && !s_axis_tready)
		else $error("accept did not start the table access");

	a_write_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_FIN) && (op_q == OP_CHECK))
		else $error("table written outside the update stage");

	a_ban_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res_ban_q && res_allowed_q) && !(res_created_q && res_found_q))
		else $error("inconsistent result flags");

	a_check_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[slot_q])
		else $error("checked entry not marked valid");

	a_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (op_q == OP_REMOVE) |=> !valid_q[slot_q])
		else $error("removed entry still valid");
`endif

endmodule
